// ===== rtl/ges_pkg.sv =====
package ges_pkg;

    localparam int MAX_N_DEF = 16;
    localparam int FRAC_DEF  = 16;
    localparam int VAL_W     = 48;
    localparam int ELEM_W    = 32;
    localparam int CFG_W     = 5;

    localparam logic [CFG_W-1:0] SIZE_RST = 5'd16;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SINGULAR = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    // Largest positive value, and the magnitude of the most negative one.
    localparam logic [VAL_W-1:0] LIM_POS = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] LIM_NEG = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic [3:0]               row_index;
        logic [4:0]               column_index;
        logic signed [ELEM_W-1:0] element_value;
        logic                     last_element;
    } t_item;

    typedef struct packed {
        logic [3:0]               unknown_index;
        logic signed [ELEM_W-1:0] solution_value;
        logic [1:0]               status;
        logic                     last_result;
    } t_result;

    // A classified word on its way from the front to the back.
    typedef struct packed {
        logic                     wr;
        logic                     last;
        logic [3:0]               row;
        logic [4:0]               col;
        logic signed [ELEM_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic             sat;
        logic [VAL_W-1:0] value;
    } t_clip;

    typedef enum logic [4:0] {
        S_IDLE, S_PIV_RD, S_PIV_CHK, S_SRCH_RD, S_SRCH_CHK,
        S_SW_RD1, S_SW_RD2, S_SW_WR1, S_SW_WR2,
        S_ROW_RD, S_ROW_DIV0, S_ROW_DIV,
        S_EL_RD1, S_EL_RD2, S_EL_CAP, S_EL_MUL,
        S_BS_RD, S_BS_SUM, S_BS_TR_RD, S_BS_TR_MUL0, S_BS_TR_MUL,
        S_BS_DG_RD, S_BS_DG_CHK, S_BS_DIV,
        S_SCAN_RD, S_SCAN_CHK, S_OUT_RD, S_OUT_PUT
    } t_state;

    function automatic logic [VAL_W-1:0] f_mag(input logic [VAL_W-1:0] v);
        f_mag = v[VAL_W-1] ? (VAL_W'(0) - v) : v;
    endfunction

    // Saturates a signed magnitude to the internal value range.
    function automatic t_clip f_clip(input logic neg, input logic [127:0] mag);
        t_clip r;
        r.sat = 1'b0;
        if (neg) begin
            if (mag > 128'(LIM_NEG)) begin
                r.sat   = 1'b1;
                r.value = LIM_NEG;
            end else begin
                r.value = VAL_W'(128'd0 - mag);
            end
        end else begin
            if (mag > 128'(LIM_POS)) begin
                r.sat   = 1'b1;
                r.value = LIM_POS;
            end else begin
                r.value = VAL_W'(mag);
            end
        end
        return r;
    endfunction

    function automatic t_clip f_clip_sub(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
        logic [VAL_W:0] d;
        logic [VAL_W:0] m;
        d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        m = d[VAL_W] ? ((VAL_W+1)'(0) - d) : d;
        return f_clip(d[VAL_W], 128'(m));
    endfunction

endpackage

// ===== rtl/gaussian_elimination_solver_unit.sv =====
// Solves an n-by-n linear system in signed fixed point by Gaussian elimination
// with row swapping on zero pivots, followed by back substitution.
// Input channel (push/full): one word is one matrix element with its row and
// column; column n holds the right-hand side. The word flagged last_element
// starts the solve once it is stored. Words are taken one per cycle while
// the matrix loads; a two-entry queue decouples the front from the solver.
// Result channel (empty/pop): n words, unknowns 0 to n-1 in order, all with
// one status; the last carries last_result. A result waits in an output
// register, so the solver halts while the receiver stalls, and new matrix
// words are still taken into the queue meanwhile.
// Solve time is set by the shared multiplier and divider: each multiply-
// subtract covers three 48x16 partial products, rounding, matrix memory
// reads and write-back, and each division yields one quotient bit per
// cycle, plus a range scan and output step per unknown.
// The size register i_cfg_wdata sets n; it resets to 16. Reset empties the
// queue and the output register; the matrix memory is undefined until written.
module gaussian_elimination_solver_unit #(
    parameter int MAX_N         = ges_pkg::MAX_N_DEF,
    parameter int FRACTION_BITS = ges_pkg::FRAC_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    input  ges_pkg::t_item            i_item,
    output logic                      full,
    output logic                      empty,
    input  logic                      pop,
    output ges_pkg::t_result          o_result,
    input  logic                      i_cfg_we,
    input  logic [ges_pkg::CFG_W-1:0] i_cfg_wdata
);
    import ges_pkg::*;

    logic [CFG_W-1:0] r_size;
    logic             w_cmd_valid;
    logic             w_cmd_pop;
    t_cmd             w_cmd;
    logic             w_res_valid;

    // The size register is to be written only while the solver is idle; the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RST;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_wdata;
        end
    end

    // The front classifies each word and queues it for the solver.
    ges_front #(.MAX_N(MAX_N)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    // The back stores elements, runs the solve and drives the result register.
    ges_back #(.MAX_N(MAX_N), .FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_size      (r_size),
        .i_pop       (pop),
        .o_res_valid (w_res_valid),
        .o_res       (o_result)
    );

    assign empty = !w_res_valid;

    // The solver never takes a word from an empty queue.
    a_cmd_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid)
        else $error("solver popped an empty command queue");

    // A singular result always carries a zero solution value.
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status == ST_SINGULAR) |-> o_result.solution_value == '0)
        else $error("singular result with nonzero value");

    // Within one run the unknowns come out in increasing order.
    a_index_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_result.last_result) ##1 !empty
        |-> o_result.unknown_index == 4'($past(o_result.unknown_index) + 4'd1))
        else $error("unknown index out of order");

endmodule

// ===== rtl/ges_ram.sv =====
module ges_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ges_mul.sv =====
module ges_mul #(
    parameter int FRACTION_BITS = ges_pkg::FRAC_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ges_pkg::VAL_W-1:0]  i_a,
    input  logic [ges_pkg::VAL_W-1:0]  i_b,
    output logic                       o_done,
    output ges_pkg::t_clip             o_res
);
    import ges_pkg::*;

    localparam int CHUNK = 16;
    localparam int NCH   = VAL_W / CHUNK;
    localparam int CNT_W = $clog2(NCH);
    localparam int PW    = 2 * VAL_W;
    localparam logic [PW-1:0] RND = PW'(1) << (FRACTION_BITS - 1);

    logic             r_busy;
    logic             r_fin;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [PW-1:0]    r_acc;
    logic [VAL_W-1:0] r_ma;
    logic [VAL_W-1:0] r_mb;
    logic             r_neg;
    t_clip            r_res;

    logic [CHUNK-1:0]       w_chunk;
    logic [VAL_W+CHUNK-1:0] w_prod;
    logic [PW-1:0]          w_part;
    logic [PW-1:0]          w_round;

    // One 48x16 partial product per cycle, summed over three chunks of b.
    assign w_chunk = r_mb[int'(r_cnt)*CHUNK +: CHUNK];
    assign w_prod  = r_ma * w_chunk;
    assign w_part  = PW'(w_prod) << (int'(r_cnt) * CHUNK);
    assign w_round = (r_acc + RND) >> FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(NCH - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= f_mag(i_a);
            r_mb  <= f_mag(i_b);
            r_neg <= i_a[VAL_W-1] ^ i_b[VAL_W-1];
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_part;
        end else if (r_fin) begin
            r_res <= f_clip(r_neg, 128'(w_round));
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/ges_div.sv =====
module ges_div #(
    parameter int FRACTION_BITS = ges_pkg::FRAC_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ges_pkg::VAL_W-1:0]  i_a,
    input  logic [ges_pkg::VAL_W-1:0]  i_b,
    output logic                       o_done,
    output ges_pkg::t_clip             o_res
);
    import ges_pkg::*;

    localparam int NW    = VAL_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(NW);

    logic             r_busy;
    logic             r_rnd;
    logic             r_fin;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_num;
    logic [NW-1:0]    r_q;
    logic [VAL_W-1:0] r_rem;
    logic [VAL_W-1:0] r_mb;
    logic             r_neg;
    t_clip            r_res;

    logic [VAL_W:0] w_trial;
    logic           w_ge;
    logic [VAL_W:0] w_diff;

    // Restoring division, one quotient bit per cycle.
    assign w_trial = {r_rem, r_num[NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_mb};
    assign w_diff  = w_trial - {1'b0, r_mb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rnd  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_rnd  <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end else if (r_rnd) begin
                r_rnd <= 1'b0;
                r_fin <= 1'b1;
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {f_mag(i_a), {FRACTION_BITS{1'b0}}};
            r_mb  <= f_mag(i_b);
            r_neg <= i_a[VAL_W-1] ^ i_b[VAL_W-1];
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= w_ge ? VAL_W'(w_diff) : VAL_W'(w_trial);
            r_q   <= {r_q[NW-2:0], w_ge};
        end else if (r_rnd) begin
            // Round to nearest, ties away from zero.
            if ({r_rem, 1'b0} >= {1'b0, r_mb}) begin
                r_q <= r_q + 1'b1;
            end
        end else if (r_fin) begin
            r_res <= f_clip(r_neg, 128'(r_q));
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/ges_front.sv =====
module ges_front #(
    parameter int MAX_N = ges_pkg::MAX_N_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ges_pkg::t_item   i_item,
    output logic             o_full,
    output logic             o_cmd_valid,
    output ges_pkg::t_cmd    o_cmd,
    input  logic             i_cmd_pop
);
    import ges_pkg::*;

    localparam int QD  = 2;
    localparam int PTW = $clog2(QD);
    localparam int CTW = $clog2(QD + 1);

    t_cmd           r_q [QD];
    logic [PTW-1:0] r_wp;
    logic [PTW-1:0] r_rp;
    logic [CTW-1:0] r_cnt;

    logic w_in;
    logic w_out;
    t_cmd w_cmd;

    assign o_full      = r_cnt == CTW'(QD);
    assign o_cmd_valid = r_cnt != '0;
    assign o_cmd       = r_q[r_rp];
    assign w_in        = i_push && !o_full;
    assign w_out       = i_cmd_pop && o_cmd_valid;

    // Elements outside the matrix are dropped but may still start a solve.
    always_comb begin
        w_cmd.wr    = (int'(i_item.row_index) < MAX_N) && (int'(i_item.column_index) <= MAX_N);
        w_cmd.last  = i_item.last_element;
        w_cmd.row   = i_item.row_index;
        w_cmd.col   = i_item.column_index;
        w_cmd.value = i_item.element_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_in) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_out) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_in && !w_out) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_out && !w_in) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

// ===== rtl/ges_back.sv =====
module ges_back #(
    parameter int MAX_N         = ges_pkg::MAX_N_DEF,
    parameter int FRACTION_BITS = ges_pkg::FRAC_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  ges_pkg::t_cmd             i_cmd,
    output logic                      o_cmd_pop,
    input  logic [ges_pkg::CFG_W-1:0] i_size,
    input  logic                      i_pop,
    output logic                      o_res_valid,
    output ges_pkg::t_result          o_res
);
    import ges_pkg::*;

    localparam int CW    = $clog2(MAX_N + 1);
    localparam int XW    = $clog2(MAX_N);
    localparam int DEPTH = MAX_N * (MAX_N + 1);
    localparam int AW    = $clog2(DEPTH);

    t_state           r_state, n_state;
    logic [CW-1:0]    r_n, n_n;
    logic [CW-1:0]    r_k, n_k;
    logic [CW-1:0]    r_i, n_i;
    logic [CW-1:0]    r_j, n_j;
    logic             r_sat, n_sat;
    logic             r_sing, n_sing;
    logic             r_ovalid, n_ovalid;
    logic [VAL_W-1:0] r_piv, n_piv;
    logic [VAL_W-1:0] r_f, n_f;
    logic [VAL_W-1:0] r_a, n_a;
    logic [VAL_W-1:0] r_sum, n_sum;
    t_result          r_ores, n_ores;

    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [VAL_W-1:0] w_wdata;
    logic [AW-1:0]    w_raddr;
    logic [VAL_W-1:0] w_rdata;
    logic             w_xwe;
    logic [VAL_W-1:0] w_xrdata;
    logic             w_mul_start;
    logic [VAL_W-1:0] w_mul_b;
    logic             w_mul_done;
    t_clip            w_mul_res;
    logic             w_div_start;
    logic [VAL_W-1:0] w_div_a;
    logic [VAL_W-1:0] w_div_b;
    logic             w_div_done;
    t_clip            w_div_res;
    t_clip            w_sub;
    logic [CW-1:0]    w_nclamp;
    logic             w_fits;
    logic [ELEM_W-1:0] w_x32;
    logic             w_free;

    function automatic logic [AW-1:0] f_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return AW'(int'(r) * (MAX_N + 1) + int'(c));
    endfunction

    ges_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_mat (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ges_ram #(.WIDTH(VAL_W), .DEPTH(MAX_N)) u_sol (
        .i_clk   (i_clk),
        .i_we    (w_xwe),
        .i_waddr (r_i[XW-1:0]),
        .i_wdata (w_div_res.value),
        .i_raddr (r_j[XW-1:0]),
        .o_rdata (w_xrdata)
    );

    ges_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_rdata),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res)
    );

    ges_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_a     (w_div_a),
        .i_b     (w_div_b),
        .o_done  (w_div_done),
        .o_res   (w_div_res)
    );

    assign w_mul_b = (r_state == S_BS_TR_MUL0) ? w_xrdata : r_f;
    assign w_div_a = (r_state == S_BS_DG_CHK) ? r_sum : w_rdata;
    assign w_div_b = (r_state == S_BS_DG_CHK) ? w_rdata : r_piv;
    assign w_sub   = f_clip_sub((r_state == S_EL_MUL) ? r_a : r_sum, w_mul_res.value);
    assign w_fits  = (&w_xrdata[VAL_W-1:ELEM_W-1]) || !(|w_xrdata[VAL_W-1:ELEM_W-1]);
    assign w_x32   = w_fits ? w_xrdata[ELEM_W-1:0]
                   : (w_xrdata[VAL_W-1] ? {1'b1, {(ELEM_W-1){1'b0}}}
                                        : {1'b0, {(ELEM_W-1){1'b1}}});
    assign w_free  = !r_ovalid || i_pop;

    always_comb begin
        if (i_size == '0) begin
            w_nclamp = CW'(1);
        end else if (int'(i_size) > MAX_N) begin
            w_nclamp = CW'(MAX_N);
        end else begin
            w_nclamp = CW'(i_size);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_k      = r_k;
        n_i      = r_i;
        n_j      = r_j;
        n_sat    = r_sat;
        n_sing   = r_sing;
        n_ovalid = r_ovalid && !i_pop;
        n_piv    = r_piv;
        n_f      = r_f;
        n_a      = r_a;
        n_sum    = r_sum;
        n_ores   = r_ores;
        o_cmd_pop   = 1'b0;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = '0;
        w_raddr     = '0;
        w_xwe       = 1'b0;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    w_we      = i_cmd.wr;
                    w_waddr   = f_addr(CW'(i_cmd.row), CW'(i_cmd.col));
                    w_wdata   = {{(VAL_W-ELEM_W){i_cmd.value[ELEM_W-1]}}, i_cmd.value};
                    if (i_cmd.last) begin
                        n_n    = w_nclamp;
                        n_sat  = 1'b0;
                        n_sing = 1'b0;
                        n_k    = '0;
                        if (w_nclamp == CW'(1)) begin
                            n_i     = '0;
                            n_state = S_BS_RD;
                        end else begin
                            n_state = S_PIV_RD;
                        end
                    end
                end
            end
            S_PIV_RD: begin
                w_raddr = f_addr(r_k, r_k);
                n_state = S_PIV_CHK;
            end
            S_PIV_CHK: begin
                n_i = r_k + 1'b1;
                if (w_rdata != '0) begin
                    n_piv   = w_rdata;
                    n_state = S_ROW_RD;
                end else begin
                    n_state = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                w_raddr = f_addr(r_i, r_k);
                n_state = S_SRCH_CHK;
            end
            S_SRCH_CHK: begin
                // The swap moves whole stored rows, every column of the store.
                if (w_rdata != '0) begin
                    n_j     = '0;
                    n_state = S_SW_RD1;
                end else if (r_i == r_n - 1'b1) begin
                    n_sing  = 1'b1;
                    n_j     = '0;
                    n_state = S_OUT_RD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SRCH_RD;
                end
            end
            S_SW_RD1: begin
                w_raddr = f_addr(r_k, r_j);
                n_state = S_SW_RD2;
            end
            S_SW_RD2: begin
                w_raddr = f_addr(r_i, r_j);
                n_a     = w_rdata;
                n_state = S_SW_WR1;
            end
            S_SW_WR1: begin
                w_we    = 1'b1;
                w_waddr = f_addr(r_k, r_j);
                w_wdata = w_rdata;
                n_state = S_SW_WR2;
            end
            S_SW_WR2: begin
                w_we    = 1'b1;
                w_waddr = f_addr(r_i, r_j);
                w_wdata = r_a;
                if (r_j == CW'(MAX_N)) begin
                    n_state = S_PIV_RD;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_SW_RD1;
                end
            end
            S_ROW_RD: begin
                w_raddr = f_addr(r_i, r_k);
                n_state = S_ROW_DIV0;
            end
            S_ROW_DIV0: begin
                w_div_start = 1'b1;
                n_state     = S_ROW_DIV;
            end
            S_ROW_DIV: begin
                if (w_div_done) begin
                    n_f     = w_div_res.value;
                    n_sat   = r_sat || w_div_res.sat;
                    n_j     = r_k;
                    n_state = S_EL_RD1;
                end
            end
            S_EL_RD1: begin
                w_raddr = f_addr(r_k, r_j);
                n_state = S_EL_RD2;
            end
            S_EL_RD2: begin
                w_raddr     = f_addr(r_i, r_j);
                w_mul_start = 1'b1;
                n_state     = S_EL_CAP;
            end
            S_EL_CAP: begin
                n_a     = w_rdata;
                n_state = S_EL_MUL;
            end
            S_EL_MUL: begin
                if (w_mul_done) begin
                    w_we    = 1'b1;
                    w_waddr = f_addr(r_i, r_j);
                    w_wdata = w_sub.value;
                    n_sat   = r_sat || w_mul_res.sat || w_sub.sat;
                    if (r_j != r_n) begin
                        n_j     = r_j + 1'b1;
                        n_state = S_EL_RD1;
                    end else if (r_i != r_n - 1'b1) begin
                        n_i     = r_i + 1'b1;
                        n_state = S_ROW_RD;
                    end else if (int'(r_k) + 2 >= int'(r_n)) begin
                        n_i     = r_n - 1'b1;
                        n_state = S_BS_RD;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_PIV_RD;
                    end
                end
            end
            S_BS_RD: begin
                w_raddr = f_addr(r_i, r_n);
                n_state = S_BS_SUM;
            end
            S_BS_SUM: begin
                n_sum = w_rdata;
                n_j   = r_i + 1'b1;
                if (r_i + 1'b1 == r_n) begin
                    n_state = S_BS_DG_RD;
                end else begin
                    n_state = S_BS_TR_RD;
                end
            end
            S_BS_TR_RD: begin
                w_raddr = f_addr(r_i, r_j);
                n_state = S_BS_TR_MUL0;
            end
            S_BS_TR_MUL0: begin
                w_mul_start = 1'b1;
                n_state     = S_BS_TR_MUL;
            end
            S_BS_TR_MUL: begin
                if (w_mul_done) begin
                    n_sum = w_sub.value;
                    n_sat = r_sat || w_mul_res.sat || w_sub.sat;
                    if (r_j == r_n - 1'b1) begin
                        n_state = S_BS_DG_RD;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = S_BS_TR_RD;
                    end
                end
            end
            S_BS_DG_RD: begin
                w_raddr = f_addr(r_i, r_i);
                n_state = S_BS_DG_CHK;
            end
            S_BS_DG_CHK: begin
                if (w_rdata == '0) begin
                    n_sing  = 1'b1;
                    n_j     = '0;
                    n_state = S_OUT_RD;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_BS_DIV;
                end
            end
            S_BS_DIV: begin
                if (w_div_done) begin
                    w_xwe = 1'b1;
                    n_sat = r_sat || w_div_res.sat;
                    if (r_i == '0) begin
                        n_j     = '0;
                        n_state = S_SCAN_RD;
                    end else begin
                        n_i     = r_i - 1'b1;
                        n_state = S_BS_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                n_sat = r_sat || !w_fits;
                if (r_j == r_n - 1'b1) begin
                    n_j     = '0;
                    n_state = S_OUT_RD;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_OUT_RD: begin
                n_state = S_OUT_PUT;
            end
            S_OUT_PUT: begin
                if (w_free) begin
                    n_ovalid                = 1'b1;
                    n_ores.unknown_index    = 4'(r_j);
                    n_ores.solution_value   = r_sing ? '0 : w_x32;
                    n_ores.status           = r_sing ? ST_SINGULAR : (r_sat ? ST_SAT : ST_OK);
                    n_ores.last_result      = r_j == r_n - 1'b1;
                    if (r_j == r_n - 1'b1) begin
                        n_state = S_IDLE;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_n      <= '0;
            r_k      <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_sat    <= 1'b0;
            r_sing   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_n      <= n_n;
            r_k      <= n_k;
            r_i      <= n_i;
            r_j      <= n_j;
            r_sat    <= n_sat;
            r_sing   <= n_sing;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_piv  <= n_piv;
        r_f    <= n_f;
        r_a    <= n_a;
        r_sum  <= n_sum;
        r_ores <= n_ores;
    end

    assign o_res_valid = r_ovalid;
    assign o_res       = r_ores;

endmodule
